// ===== rtl/mtjm_pkg.sv =====
// types and constants shared by the tick jitter monitor and its channel interfaces
// no dependencies

package mtjm_pkg;

    localparam int unsigned CMD_W         = 1;
    localparam int unsigned STAMP_W       = 32;
    localparam int unsigned STAT_W        = 32;
    localparam int unsigned COUNT_W       = 16;
    localparam int unsigned PERIOD_W      = 24;
    localparam int unsigned PCT_W         = 10;
    localparam int unsigned CFG_DATA_W    = 24;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned LATE_PROD_W   = PERIOD_W + PCT_W;

    localparam logic [STAT_W-1:0]   STAT_MAX      = '1;
    localparam int unsigned         PCT_BASE      = 100;

    localparam logic [COUNT_W-1:0]  SPB_RST       = 16'd1;
    localparam logic [COUNT_W-1:0]  BPO_RST       = 16'd10;
    localparam logic [PERIOD_W-1:0] BAL_PERIOD_RST = 24'd1000;
    localparam logic [PERIOD_W-1:0] OUT_PERIOD_RST = 24'd10000;
    localparam logic [PCT_W-1:0]    LATE_PCT_RST  = 10'd10;
    localparam logic [LATE_PROD_W-1:0] LATE_PROD_RST =
        LATE_PROD_W'(BAL_PERIOD_RST) * LATE_PROD_W'(LATE_PCT_RST);

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE      = 1'b0,
        CMD_CLEAR_STATS = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_BALANCE = 3'd0,
        CFG_BALANCES_PER_OUTER  = 3'd1,
        CFG_BALANCE_PERIOD      = 3'd2,
        CFG_OUTER_PERIOD        = 3'd3,
        CFG_LATE_PERCENTAGE     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              balance_fire;
        logic [STAT_W-1:0] balance_interval;
        logic              outer_fire;
        logic [STAT_W-1:0] outer_interval;
        logic [STAT_W-1:0] iteration_count;
        logic [STAT_W-1:0] worst_jitter;
        logic [STAT_W-1:0] late_count;
    } t_result;

endpackage

// ===== rtl/mtjm_in_if.sv =====
// sample request channel: valid/ready handshake with command and timestamp
// depends on mtjm_pkg

interface mtjm_in_if;
    import mtjm_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [STAMP_W-1:0] sample_time;

    modport source (output valid, command, sample_time, input ready);
    modport sink   (input valid, command, sample_time, output ready);
endinterface

// ===== rtl/mtjm_out_if.sv =====
// result channel: valid/ready handshake with tick flags, intervals and statistics
// depends on mtjm_pkg

interface mtjm_out_if;
    import mtjm_pkg::*;

    logic              valid;
    logic              ready;
    logic              balance_fire;
    logic [STAT_W-1:0] balance_interval;
    logic              outer_fire;
    logic [STAT_W-1:0] outer_interval;
    logic [STAT_W-1:0] iteration_count;
    logic [STAT_W-1:0] worst_jitter;
    logic [STAT_W-1:0] late_count;

    modport source (output valid, balance_fire, balance_interval, outer_fire,
                    outer_interval, iteration_count, worst_jitter, late_count,
                    input ready);
    modport sink   (input valid, balance_fire, balance_interval, outer_fire,
                    outer_interval, iteration_count, worst_jitter, late_count,
                    output ready);
endinterface

// ===== rtl/multirate_tick_jitter_monitor.sv =====
// multirate tick jitter monitor: decimates sample requests into balance and outer
// ticks, reports intervals and keeps jitter and lateness statistics
// depends on mtjm_pkg, mtjm_in_if, mtjm_out_if
//
//   channel   direction  handshake     contents
//   i_smp     in         valid/ready   command, sample_time
//   o_res     out        valid/ready   tick flags, intervals, statistics
//   i_cfg_*   in         write enable  register index, write data
//
// one request per cycle unless a stalled result blocks it, one result per request
// in the result register; all tick, interval and statistics logic sits before that register
// i_smp.ready is high whenever the result register is empty or is being drained
// a stalled result holds and blocks the next request only while o_res.ready is low
// synchronous reset restores register defaults and clears counters and statistics
// the late threshold product is registered from the configuration write itself

module multirate_tick_jitter_monitor #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mtjm_in_if.sink                               i_smp,
    mtjm_out_if.source                            o_res,
    input  logic                                  i_cfg_we,
    input  mtjm_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [mtjm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mtjm_pkg::*;

    localparam int unsigned DEV_W = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;
    localparam int unsigned CMP_W = DEV_W + PCT_W;

    // configuration
    logic [COUNT_W-1:0]     r_spb,        n_spb;
    logic [COUNT_W-1:0]     r_bpo,        n_bpo;
    logic [PERIOD_W-1:0]    r_bal_period, n_bal_period;
    logic [PERIOD_W-1:0]    r_out_period, n_out_period;
    logic [PCT_W-1:0]       r_late_pct,   n_late_pct;
    logic [LATE_PROD_W-1:0] r_late_prod;

    // tick state and statistics
    logic [COUNT_W-1:0]     r_smp_cnt,    n_smp_cnt;
    logic [COUNT_W-1:0]     r_bal_cnt,    n_bal_cnt;
    logic [TIME_WIDTH-1:0]  r_last_bal,   n_last_bal;
    logic                   r_last_bal_vld, n_last_bal_vld;
    logic [TIME_WIDTH-1:0]  r_last_out,   n_last_out;
    logic                   r_last_out_vld, n_last_out_vld;
    logic [STAT_W-1:0]      r_ticks,      n_ticks;
    logic [STAT_W-1:0]      r_jitter,     n_jitter;
    logic [STAT_W-1:0]      r_late,       n_late;

    logic                   r_out_valid;
    t_result                r_res,        n_res;

    logic                   w_acc;
    logic [TIME_WIDTH-1:0]  w_now;
    logic [COUNT_W-1:0]     w_smp_inc;
    logic [COUNT_W-1:0]     w_bal_inc;
    logic [TIME_WIDTH-1:0]  w_bal_iv;
    logic [TIME_WIDTH-1:0]  w_out_iv;
    logic [DEV_W-1:0]       w_iv_ext;
    logic [DEV_W-1:0]       w_bp_ext;
    logic                   w_over;
    logic [DEV_W-1:0]       w_dev;
    logic [STAT_W-1:0]      w_dev_sat;
    logic                   w_late;

    assign i_smp.ready = !r_out_valid || o_res.ready;
    assign w_acc       = i_smp.valid && i_smp.ready;

    // configuration writes, with the late product following the written values
    always_comb begin
        n_spb        = r_spb;
        n_bpo        = r_bpo;
        n_bal_period = r_bal_period;
        n_out_period = r_out_period;
        n_late_pct   = r_late_pct;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLES_PER_BALANCE: n_spb        = i_cfg_data[COUNT_W-1:0];
                CFG_BALANCES_PER_OUTER:  n_bpo        = i_cfg_data[COUNT_W-1:0];
                CFG_BALANCE_PERIOD:      n_bal_period = i_cfg_data[PERIOD_W-1:0];
                CFG_OUTER_PERIOD:        n_out_period = i_cfg_data[PERIOD_W-1:0];
                CFG_LATE_PERCENTAGE:     n_late_pct   = i_cfg_data[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb        <= SPB_RST;
            r_bpo        <= BPO_RST;
            r_bal_period <= BAL_PERIOD_RST;
            r_out_period <= OUT_PERIOD_RST;
            r_late_pct   <= LATE_PCT_RST;
            r_late_prod  <= LATE_PROD_RST;
        end else begin
            r_spb        <= n_spb;
            r_bpo        <= n_bpo;
            r_bal_period <= n_bal_period;
            r_out_period <= n_out_period;
            r_late_pct   <= n_late_pct;
            r_late_prod  <= LATE_PROD_W'(n_bal_period) * LATE_PROD_W'(n_late_pct);
        end
    end

    // interval, deviation and lateness
    assign w_now     = TIME_WIDTH'(i_smp.sample_time);
    assign w_smp_inc = r_smp_cnt + 1'b1;
    assign w_bal_inc = r_bal_cnt + 1'b1;
    assign w_bal_iv  = w_now - r_last_bal;
    assign w_out_iv  = w_now - r_last_out;
    assign w_iv_ext  = DEV_W'(w_bal_iv);
    assign w_bp_ext  = DEV_W'(r_bal_period);
    assign w_over    = w_iv_ext > w_bp_ext;
    assign w_dev     = w_over ? (w_iv_ext - w_bp_ext) : (w_bp_ext - w_iv_ext);
    assign w_dev_sat = (DEV_W > STAT_W && w_dev > DEV_W'(STAT_MAX)) ? STAT_MAX
                                                                    : STAT_W'(w_dev);
    // interval above period + floor(period * pct / 100) as an exact scaled compare
    assign w_late    = w_over &&
                       (CMP_W'(w_dev) * CMP_W'(PCT_BASE) > CMP_W'(r_late_prod));

    always_comb begin
        n_smp_cnt      = r_smp_cnt;
        n_bal_cnt      = r_bal_cnt;
        n_last_bal     = r_last_bal;
        n_last_bal_vld = r_last_bal_vld;
        n_last_out     = r_last_out;
        n_last_out_vld = r_last_out_vld;
        n_ticks        = r_ticks;
        n_jitter       = r_jitter;
        n_late         = r_late;
        n_res          = r_res;
        n_res.balance_fire     = 1'b0;
        n_res.balance_interval = '0;
        n_res.outer_fire       = 1'b0;
        n_res.outer_interval   = '0;

        if (w_acc) begin
            if (t_cmd'(i_smp.command) == CMD_CLEAR_STATS) begin
                n_ticks  = '0;
                n_jitter = '0;
                n_late   = '0;
            end else if (w_smp_inc >= r_spb) begin
                n_smp_cnt          = '0;
                n_res.balance_fire = 1'b1;
                if (r_last_bal_vld) begin
                    n_res.balance_interval = STAT_W'(w_bal_iv);
                    if (w_dev_sat > r_jitter) begin
                        n_jitter = w_dev_sat;
                    end
                    if (w_late && r_late != STAT_MAX) begin
                        n_late = r_late + 1'b1;
                    end
                end else begin
                    n_res.balance_interval = STAT_W'(r_bal_period);
                end
                n_last_bal     = w_now;
                n_last_bal_vld = 1'b1;
                if (r_ticks != STAT_MAX) begin
                    n_ticks = r_ticks + 1'b1;
                end
                if (w_bal_inc >= r_bpo) begin
                    n_bal_cnt        = '0;
                    n_res.outer_fire = 1'b1;
                    n_res.outer_interval = r_last_out_vld ? STAT_W'(w_out_iv)
                                                          : STAT_W'(r_out_period);
                    n_last_out     = w_now;
                    n_last_out_vld = 1'b1;
                end else begin
                    n_bal_cnt = w_bal_inc;
                end
            end else begin
                n_smp_cnt = w_smp_inc;
            end
            n_res.iteration_count = n_ticks;
            n_res.worst_jitter    = n_jitter;
            n_res.late_count      = n_late;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_cnt      <= '0;
            r_bal_cnt      <= '0;
            r_last_bal     <= '0;
            r_last_bal_vld <= 1'b0;
            r_last_out     <= '0;
            r_last_out_vld <= 1'b0;
            r_ticks        <= '0;
            r_jitter       <= '0;
            r_late         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_smp_cnt      <= n_smp_cnt;
            r_bal_cnt      <= n_bal_cnt;
            r_last_bal     <= n_last_bal;
            r_last_bal_vld <= n_last_bal_vld;
            r_last_out     <= n_last_out;
            r_last_out_vld <= n_last_out_vld;
            r_ticks        <= n_ticks;
            r_jitter       <= n_jitter;
            r_late         <= n_late;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.balance_fire     = r_res.balance_fire;
    assign o_res.balance_interval = r_res.balance_interval;
    assign o_res.outer_fire       = r_res.outer_fire;
    assign o_res.outer_interval   = r_res.outer_interval;
    assign o_res.iteration_count  = r_res.iteration_count;
    assign o_res.worst_jitter     = r_res.worst_jitter;
    assign o_res.late_count       = r_res.late_count;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    a_outer_needs_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.outer_fire |-> o_res.balance_fire)
        else $error("outer tick without balance tick");

    a_idle_intervals_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.balance_fire |-> o_res.balance_interval == '0
                                               && o_res.outer_interval == '0)
        else $error("interval reported without a tick");

    a_tick_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.balance_fire |-> o_res.iteration_count != '0)
        else $error("balance tick not counted");

    a_late_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.late_count <= o_res.iteration_count)
        else $error("late count above tick count");

    a_clear_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && t_cmd'(i_smp.command) == CMD_CLEAR_STATS
        |=> o_res.valid && o_res.iteration_count == '0 && o_res.worst_jitter == '0
            && o_res.late_count == '0)
        else $error("statistics not cleared");

endmodule
